/* src/fpp_pkg.sv */
// ============================================================================
// fpp_pkg: shared types and constants of the CRC-framed packet parser
// Holds the configuration and descriptor types, the result type, register
// indexes and the bytewise CRC-16 update.
// ============================================================================
package fpp_pkg;

    // Configuration register indexes and reset values
    localparam int              CFG_IDX_W      = 2;
    localparam int              CFG_DATA_W     = 16;
    localparam logic [1:0]      CFG_HEADER     = 2'd0;
    localparam logic [1:0]      CFG_TRAILER    = 2'd1;
    localparam logic [1:0]      CFG_CRC_EN     = 2'd2;
    localparam logic [15:0]     HEADER_RESET   = 16'hAA55;
    localparam logic [15:0]     TRAILER_RESET  = 16'h55AA;
    localparam logic            CRC_EN_RESET   = 1'b1;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0]     CRC_INIT       = 16'hFFFF;
    localparam logic [15:0]     CRC_POLY       = 16'h1021;

    // Result field widths
    localparam int              PLEN_W         = 6;
    localparam int              BIDX_W         = 5;

    // Descriptor count field covers the largest supported payload limit
    localparam int              DESC_CNT_W     = 7;

    // Frame descriptor queue between front and back
    localparam int              QUEUE_DEPTH    = 2;
    localparam logic [1:0]      MAX_FRAMES     = 2'd2;

    typedef struct packed {
        logic [15:0] header_word;
        logic [15:0] trailer_word;
        logic        crc_enable;
    } cfg_t;

    typedef struct packed {
        logic [7:0]            command;
        logic [DESC_CNT_W-1:0] count;
        logic                  bank;
    } desc_t;

    typedef struct packed {
        logic [7:0]        command;
        logic [7:0]        payload_byte;
        logic [PLEN_W-1:0] payload_length;
        logic [BIDX_W-1:0] byte_index;
        logic              has_payload;
        logic              last;
    } result_t;

    // Fold one byte into the running CRC, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* src/fpp_ram.sv */
// ============================================================================
// fpp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/fpp_front.sv */
// ============================================================================
// fpp_front: byte classifier and frame checker
// Hunts for the header, checks length and CRC (if enabled), writes payload bytes
// into the current store bank and pushes a frame descriptor on a good trailer.
// ============================================================================
module fpp_front #(
    parameter int MAX_PAYLOAD = 32,
    localparam int CW = $clog2(MAX_PAYLOAD + 1),
    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int AW = IW + 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fpp_pkg::cfg_t   cfg,
    input  logic            rx_valid,
    output logic            rx_ready,
    input  logic [7:0]      rx_byte,
    input  logic            frame_done,
    output logic            st_wr_en,
    output logic [AW-1:0]   st_wr_addr,
    output logic [7:0]      st_wr_data,
    output logic            push,
    output fpp_pkg::desc_t  push_desc
);

    typedef enum logic [3:0] {
        PH_HDR1,
        PH_HDR2,
        PH_LENH,
        PH_LENL,
        PH_CMD,
        PH_DATA,
        PH_CRCH,
        PH_CRCL,
        PH_END1,
        PH_END2
    } phase_t;

    localparam int DCW = fpp_pkg::DESC_CNT_W;

    phase_t        phase_reg, phase_next;
    logic [15:0]   length_reg, length_next;
    logic [7:0]    command_reg, command_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    crc_hi_reg, crc_hi_next;
    logic          bank_reg, bank_next;
    logic [1:0]    pending_reg, pending_next;

    logic          take;
    logic          commit;
    logic [15:0]   crc_byte;
    logic [15:0]   length_full;
    logic [CW:0]   count_inc;
    phase_t        after_body;

    // Stall payload bytes and the last trailer byte while both store banks await emission
    assign rx_ready = !((pending_reg == fpp_pkg::MAX_FRAMES) &&
                        (phase_reg == PH_DATA || phase_reg == PH_END2));
    assign take        = rx_valid && rx_ready;
    assign crc_byte    = fpp_pkg::crc16_byte(crc_reg, rx_byte);
    assign length_full = {length_reg[15:8], rx_byte};
    assign count_inc   = (CW + 1)'(count_reg) + (CW + 1)'(1);
    assign after_body  = cfg.crc_enable ? PH_CRCH : PH_END1;

    // Classify the accepted byte and advance the parse phase
    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        command_next = command_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_hi_next  = crc_hi_reg;
        commit       = 1'b0;
        st_wr_en     = 1'b0;
        if (take)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (rx_byte == cfg.header_word[15:8])
                    begin
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    if (rx_byte == cfg.header_word[7:0])
                    begin
                        crc_next   = fpp_pkg::CRC_INIT;
                        phase_next = PH_LENH;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_LENH:
                begin
                    length_next = {rx_byte, 8'h00};
                    crc_next    = crc_byte;
                    phase_next  = PH_LENL;
                end
                PH_LENL:
                begin
                    length_next = length_full;
                    crc_next    = crc_byte;
                    if (length_full == 16'd0 || length_full > 16'(MAX_PAYLOAD + 1))
                    begin
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    command_next = rx_byte;
                    crc_next     = crc_byte;
                    count_next   = '0;
                    phase_next   = (length_reg == 16'd1) ? after_body : PH_DATA;
                end
                PH_DATA:
                begin
                    if (count_reg < CW'(MAX_PAYLOAD))
                    begin
                        st_wr_en = 1'b1;
                    end
                    crc_next   = crc_byte;
                    count_next = count_inc[CW-1:0];
                    if (17'(count_inc) >= ({1'b0, length_reg} - 17'd1) ||
                        count_inc >= (CW + 1)'(MAX_PAYLOAD))
                    begin
                        phase_next = after_body;
                    end
                end
                PH_CRCH:
                begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRCL;
                end
                PH_CRCL:
                begin
                    phase_next = ({crc_hi_reg, rx_byte} == crc_reg) ? PH_END1 : PH_HDR1;
                end
                PH_END1:
                begin
                    phase_next = (rx_byte == cfg.trailer_word[15:8]) ? PH_END2 : PH_HDR1;
                end
                PH_END2:
                begin
                    commit     = (rx_byte == cfg.trailer_word[7:0]);
                    phase_next = PH_HDR1;
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    // Flip bank on each committed frame; track frames not yet emitted
    always_comb
    begin
        bank_next = bank_reg ^ commit;
        unique case ({commit, frame_done})
            2'b10:   pending_next = pending_reg + 2'd1;
            2'b01:   pending_next = pending_reg - 2'd1;
            default: pending_next = pending_reg;
        endcase
    end

    assign st_wr_addr = {bank_reg, IW'(count_reg)};
    assign st_wr_data = rx_byte;
    assign push       = commit;
    assign push_desc  = '{command: command_reg, count: DCW'(count_reg), bank: bank_reg};

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            length_reg  <= '0;
            command_reg <= '0;
            count_reg   <= '0;
            crc_reg     <= fpp_pkg::CRC_INIT;
            crc_hi_reg  <= '0;
            bank_reg    <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_hi_reg  <= crc_hi_next;
            bank_reg    <= bank_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* src/fpp_queue.sv */
// ============================================================================
// fpp_queue: frame descriptor queue
// Short FIFO that decouples the byte parser from the result emitter.
// ============================================================================
module fpp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fpp_pkg::desc_t  push_desc,
    input  logic            pop,
    output logic            pop_valid,
    output fpp_pkg::desc_t  pop_desc
);

    localparam int DEPTH = fpp_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    fpp_pkg::desc_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  fill_reg, fill_next;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + NW'(1);
            2'b01:   fill_next = fill_reg - NW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store pushed descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign pop_valid = (fill_reg != '0);
    assign pop_desc  = entry_reg[rd_ptr_reg];

endmodule

/* src/fpp_back.sv */
// ============================================================================
// fpp_back: result emitter
// Takes one frame descriptor at a time and plays out one result per stored
// payload byte, or a single command-only result, through an output register.
// ============================================================================
module fpp_back #(
    parameter int MAX_PAYLOAD = 32,
    localparam int CW = $clog2(MAX_PAYLOAD + 1),
    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int AW = IW + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              desc_valid,
    input  fpp_pkg::desc_t    desc,
    output logic              pop,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [7:0]        rd_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fpp_pkg::result_t  result,
    output logic              frame_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    localparam int PLEN_W = fpp_pkg::PLEN_W;
    localparam int BIDX_W = fpp_pkg::BIDX_W;

    state_t            state_reg, state_next;
    logic [7:0]        command_reg, command_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              bank_reg, bank_next;
    logic [IW-1:0]     idx_reg, idx_next;
    fpp_pkg::result_t  result_reg, result_next;
    logic              valid_reg, valid_next;
    logic              idx_is_last;

    assign idx_is_last = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) == (CW + 1)'(count_reg);

    // Sequence reads of the store bank and load the output register
    always_comb
    begin
        state_next   = state_reg;
        command_next = command_reg;
        count_next   = count_reg;
        bank_next    = bank_reg;
        idx_next     = idx_reg;
        result_next  = result_reg;
        valid_next   = valid_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = {bank_reg, idx_reg};
        frame_done   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (desc_valid)
                begin
                    pop          = 1'b1;
                    command_next = desc.command;
                    count_next   = CW'(desc.count);
                    bank_next    = desc.bank;
                    idx_next     = '0;
                    if (desc.count == '0)
                    begin
                        result_next = '{command: desc.command, payload_byte: 8'h00,
                                        payload_length: '0, byte_index: '0,
                                        has_payload: 1'b0, last: 1'b1};
                        valid_next  = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = {desc.bank, IW'(0)};
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                result_next = '{command: command_reg, payload_byte: rd_data,
                                payload_length: PLEN_W'(count_reg),
                                byte_index: BIDX_W'(idx_reg),
                                has_payload: 1'b1, last: idx_is_last};
                valid_next  = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (result_reg.last)
                    begin
                        frame_done = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        rd_en      = 1'b1;
                        rd_addr    = {bank_reg, idx_reg + IW'(1)};
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            command_reg <= '0;
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            idx_reg     <= '0;
            result_reg  <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            bank_reg    <= bank_next;
            idx_reg     <= idx_next;
            result_reg  <= result_next;
            valid_reg   <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

/* src/crc_framed_packet_parser_core.sv */
// ============================================================================
// crc_framed_packet_parser_core: length-prefixed frame parser, CRC-16 check
// Receives a byte stream, validates framed packets and emits their contents.
// ============================================================================
// Usage:
//   rx channel  (rx_valid/rx_ready/rx_byte): one received byte per
//   transaction. Bytes are taken one per cycle; rx_ready drops only on a
//   payload or last trailer byte while two frames still await emission.
//   out channel (out_valid/out_ready/...): one transaction per payload byte of
//   an accepted frame, or one command-only transaction, with last marking the
//   end of the frame.
//   Timing: with the emitter free, a frame's first result passes the descriptor
//   queue, a store read (none for a command-only frame) and the output register;
//   each further result, once the previous one is taken, passes one store read
//   and the output register load.
//   The payload store has two banks, so one frame can be received while the
//   previous one is still being emitted.
//   Configuration (cfg_write/cfg_index/cfg_data) writes header_word,
//   trailer_word and crc_enable; write only while the block is idle.
//   Reset: registers return to 0xAA55 / 0x55AA / CRC on, the parser hunts
//   for a header and no result is pending. Store contents are not cleared.
//   A stalled receiver holds the current result; parsing goes on meanwhile.
// ============================================================================
module crc_framed_packet_parser_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  command,
    output logic [7:0]  payload_byte,
    output logic [5:0]  payload_length,
    output logic [4:0]  byte_index,
    output logic        has_payload,
    output logic        last
);

    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int AW = IW + 1;
    localparam int STORE_DEPTH = 2 ** AW;

    fpp_pkg::cfg_t    cfg_reg, cfg_next;
    fpp_pkg::desc_t   push_desc;
    fpp_pkg::desc_t   pop_desc;
    fpp_pkg::result_t result;

    logic             push;
    logic             pop;
    logic             pop_valid;
    logic             frame_done;
    logic             st_wr_en;
    logic [AW-1:0]    st_wr_addr;
    logic [7:0]       st_wr_data;
    logic             st_rd_en;
    logic [AW-1:0]    st_rd_addr;
    logic [7:0]       st_rd_data;

    // Decode configuration writes; drop writes beyond the register list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                fpp_pkg::CFG_HEADER:  cfg_next.header_word  = cfg_data;
                fpp_pkg::CFG_TRAILER: cfg_next.trailer_word = cfg_data;
                fpp_pkg::CFG_CRC_EN:  cfg_next.crc_enable   = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{header_word: fpp_pkg::HEADER_RESET,
                         trailer_word: fpp_pkg::TRAILER_RESET,
                         crc_enable: fpp_pkg::CRC_EN_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: parse and check incoming bytes
    fpp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .frame_done (frame_done),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Two-bank payload store
    fpp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // Descriptor queue between front and back
    fpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_desc  (pop_desc)
    );

    // Back: emit results of committed frames
    fpp_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (pop_valid),
        .desc       (pop_desc),
        .pop        (pop),
        .rd_en      (st_rd_en),
        .rd_addr    (st_rd_addr),
        .rd_data    (st_rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .frame_done (frame_done)
    );

    assign command        = result.command;
    assign payload_byte   = result.payload_byte;
    assign payload_length = result.payload_length;
    assign byte_index     = result.byte_index;
    assign has_payload    = result.has_payload;
    assign last           = result.last;

endmodule

/* src/fpp_checker.sv */
// ============================================================================
// fpp_checker: port-level checks of the frame parser
// Watches the result channel for stall behaviour and result consistency.
// ============================================================================
module fpp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] command,
    input logic [7:0] payload_byte,
    input logic [5:0] payload_length,
    input logic [4:0] byte_index,
    input logic       has_payload,
    input logic       last
);

    // Hold a stalled result transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command) &&
        $stable(payload_byte) && $stable(payload_length) &&
        $stable(byte_index) && $stable(has_payload) && $stable(last))
        else $error("result changed while stalled");

    // Command-only result is a single, zeroed transaction
    a_cmd_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_payload |-> last && payload_byte == 8'h00 &&
        byte_index == 5'd0 && payload_length == 6'd0)
        else $error("malformed command-only result");

    // Index lies within the payload and last marks its final byte
    a_index_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_payload |-> ({1'b0, byte_index} < payload_length) &&
        (last == (({1'b0, byte_index} + 6'd1) == payload_length)))
        else $error("byte index or last inconsistent with payload length");

    // Next byte of the same frame follows a taken result through a store read and the output register
    a_next_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_ready && has_payload && !last, 2) |->
        out_valid && has_payload && byte_index == ($past(byte_index, 2) + 5'd1) &&
        command == $past(command, 2))
        else $error("payload results out of sequence");

endmodule

bind crc_framed_packet_parser_core fpp_checker u_fpp_checker (.*);
